// File: hw/rtl/sbsi_pkg.sv
// Shared types and constants of the segment versus box slab intersection block.
package sbsi_pkg;

	// Width of every coordinate field on the ports.
	localparam int unsigned FIELD_W = 32;

	// Hit face codes.
	localparam logic [2:0] FACE_NONE  = 3'd0;
	localparam logic [2:0] FACE_MIN_X = 3'd1;
	localparam logic [2:0] FACE_MAX_X = 3'd2;
	localparam logic [2:0] FACE_MIN_Y = 3'd3;
	localparam logic [2:0] FACE_MAX_Y = 3'd4;
	localparam logic [2:0] FACE_MIN_Z = 3'd5;
	localparam logic [2:0] FACE_MAX_Z = 3'd6;

	// One query: segment start, displacement and box corners.
	typedef struct packed {
		logic signed [FIELD_W-1:0] origin_x;
		logic signed [FIELD_W-1:0] origin_y;
		logic signed [FIELD_W-1:0] origin_z;
		logic signed [FIELD_W-1:0] delta_x;
		logic signed [FIELD_W-1:0] delta_y;
		logic signed [FIELD_W-1:0] delta_z;
		logic signed [FIELD_W-1:0] box_min_x;
		logic signed [FIELD_W-1:0] box_min_y;
		logic signed [FIELD_W-1:0] box_min_z;
		logic signed [FIELD_W-1:0] box_max_x;
		logic signed [FIELD_W-1:0] box_max_y;
		logic signed [FIELD_W-1:0] box_max_z;
	} query_t;

	// One result: hit flag, hit point and hit face.
	typedef struct packed {
		logic                      hit;
		logic signed [FIELD_W-1:0] hit_x;
		logic signed [FIELD_W-1:0] hit_y;
		logic signed [FIELD_W-1:0] hit_z;
		logic [2:0]                hit_face;
	} result_t;

endpackage

// File: hw/rtl/sbsi_div.sv
// Pipelined restoring divider that gives a saturated, floored slab parameter.
module sbsi_div #(
	parameter int unsigned CW = 32,
	parameter int unsigned FW = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [CW:0]         un,
	input  logic [CW-1:0]       ud,
	input  logic                neg,
	output logic signed [FW+1:0] t
);

	localparam logic signed [FW+1:0] T_MAX = {2'b01, {FW{1'b1}}};
	localparam logic signed [FW+1:0] T_MIN = {2'b10, {FW{1'b0}}};

	logic [CW-1:0] r_s   [FW+1];
	logic [CW-1:0] ud_s  [FW+1];
	logic [FW:0]   q_s   [FW+1];
	logic          neg_s [FW+1];
	logic          sat_s [FW+1];

	logic          sat_c;
	logic          ge0_c;
	logic [CW:0]   r0_c;

	// First step: saturation test and the integer quotient bit.
	always_comb begin
		sat_c = un >= {ud, 1'b0};
		ge0_c = un >= {1'b0, ud};
		r0_c  = ge0_c ? (un - {1'b0, ud}) : un;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= r0_c[CW-1:0];
			ud_s[0]  <= ud;
			q_s[0]   <= {{FW{1'b0}}, ge0_c};
			neg_s[0] <= neg;
			sat_s[0] <= sat_c;
		end
	end

	// One fraction bit per stage.
	for (genvar k = 1; k <= FW; k++) begin : g_step
		logic [CW:0] r2_c;
		logic        ge_c;
		logic [CW:0] rn_c;

		always_comb begin
			r2_c = {r_s[k-1], 1'b0};
			ge_c = r2_c >= {1'b0, ud_s[k-1]};
			rn_c = ge_c ? (r2_c - {1'b0, ud_s[k-1]}) : r2_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]   <= rn_c[CW-1:0];
				ud_s[k]  <= ud_s[k-1];
				q_s[k]   <= {q_s[k-1][FW-1:0], ge_c};
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	logic signed [FW+1:0] t_c;

	// Sign and floor correction, or saturation to the range ends.
	always_comb begin
		if (sat_s[FW]) begin
			t_c = neg_s[FW] ? T_MIN : T_MAX;
		end else if (neg_s[FW]) begin
			t_c = -signed'({1'b0, q_s[FW]}) - signed'((FW+2)'(r_s[FW] != '0));
		end else begin
			t_c = signed'({1'b0, q_s[FW]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t <= t_c;
		end
	end

endmodule

// File: hw/rtl/sbsi_point.sv
// Hit point of one axis: origin plus floored displacement times t, saturated.
module sbsi_point #(
	parameter int unsigned CW = 32,
	parameter int unsigned FW = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] o,
	input  logic signed [CW-1:0] d,
	input  logic [FW:0]          th,
	output logic signed [CW-1:0] p
);

	localparam int unsigned PW = CW + FW + 2;

	logic signed [PW-1:0] prod_s5;
	logic signed [CW-1:0] o_s5;

	// Multiply the displacement by the clamped entry parameter.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= PW'(d) * PW'(signed'({1'b0, th}));
			o_s5    <= o;
		end
	end

	logic signed [PW-1:0] shr_c;
	logic signed [CW+1:0] sum_c;
	logic signed [CW-1:0] sat_c;

	// Floor the product, add the origin and clamp to the coordinate range.
	always_comb begin
		shr_c = prod_s5 >>> FW;
		sum_c = (CW+2)'(o_s5) + shr_c[CW+1:0];
		if (sum_c[CW+1:CW-1] == 3'b000 || sum_c[CW+1:CW-1] == 3'b111) begin
			sat_c = sum_c[CW-1:0];
		end else if (sum_c[CW+1]) begin
			sat_c = {1'b1, {(CW-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(CW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sat_c;
		end
	end

endmodule

// File: hw/rtl/segment_box_slab_intersect.sv
// Top level of the segment versus axis-aligned box slab intersection pipeline.
// Throughput: one query per cycle while the result is not stalled; the per-bit divider stages set the depth.
// A stalled result holds the whole pipeline in place; nothing is dropped.
// Reset clears all valid bits; payload registers are not reset.
module segment_box_slab_intersect #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_stall,
	input  sbsi_pkg::query_t  query,
	output logic              result_valid,
	input  logic              result_stall,
	output sbsi_pkg::result_t result
);

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned FW = FRAC_BITS;
	localparam int unsigned LD = FW + 2;
	localparam int unsigned OW = sbsi_pkg::FIELD_W;
	localparam logic signed [FW+1:0] T_MAX = {2'b01, {FW{1'b1}}};
	localparam logic signed [FW+1:0] T_MIN = {2'b10, {FW{1'b0}}};
	localparam logic signed [FW+1:0] T_ONE = {2'b01, {FW{1'b0}}};

	typedef struct packed {
		logic [2:0][CW-1:0] o;
		logic [2:0][CW-1:0] d;
		logic [2:0][CW-1:0] lo;
		logic [2:0][CW-1:0] hi;
		logic [2:0]         aok;
		logic [2:0]         unb;
	} side_t;

	logic en;

	// The pipeline moves whenever the output register can take a transfer.
	assign en          = !result_valid || !result_stall;
	assign query_stall = !en;

	// Field extraction: low coordinate bits, taken as signed.
	function automatic logic [CW-1:0] fld(input logic [OW-1:0] v);
		return CW'(v);
	endfunction

	logic [2:0][CW-1:0] o_c, d_c, lo_c, hi_c;

	always_comb begin
		o_c[0]  = fld(query.origin_x);
		o_c[1]  = fld(query.origin_y);
		o_c[2]  = fld(query.origin_z);
		d_c[0]  = fld(query.delta_x);
		d_c[1]  = fld(query.delta_y);
		d_c[2]  = fld(query.delta_z);
		lo_c[0] = fld(query.box_min_x);
		lo_c[1] = fld(query.box_min_y);
		lo_c[2] = fld(query.box_min_z);
		hi_c[0] = fld(query.box_max_x);
		hi_c[1] = fld(query.box_max_y);
		hi_c[2] = fld(query.box_max_z);
	end

	// Stage 1: plane distances, their magnitudes and the zero-displacement cases.
	side_t              sb_c;
	logic [2:0][CW:0]   unlo_c, unhi_c;
	logic [2:0][CW-1:0] ud_c;
	logic [2:0]         neglo_c, neghi_c;
	logic signed [CW:0] nlo_c [3];
	logic signed [CW:0] nhi_c [3];
	logic [2:0]         dneg_c, dz_c;

	always_comb begin
		sb_c.o  = o_c;
		sb_c.d  = d_c;
		sb_c.lo = lo_c;
		sb_c.hi = hi_c;
		for (int i = 0; i < 3; i++) begin
			nlo_c[i]    = signed'({lo_c[i][CW-1], lo_c[i]}) - signed'({o_c[i][CW-1], o_c[i]});
			nhi_c[i]    = signed'({hi_c[i][CW-1], hi_c[i]}) - signed'({o_c[i][CW-1], o_c[i]});
			dneg_c[i]   = d_c[i][CW-1];
			dz_c[i]     = d_c[i] == '0;
			unlo_c[i]   = nlo_c[i][CW] ? (CW+1)'(-nlo_c[i]) : nlo_c[i];
			unhi_c[i]   = nhi_c[i][CW] ? (CW+1)'(-nhi_c[i]) : nhi_c[i];
			ud_c[i]     = dneg_c[i] ? (CW)'(-signed'(d_c[i])) : d_c[i];
			neglo_c[i]  = nlo_c[i][CW] ^ dneg_c[i];
			neghi_c[i]  = nhi_c[i][CW] ^ dneg_c[i];
			sb_c.unb[i] = dz_c[i];
			sb_c.aok[i] = !dz_c[i] || (nlo_c[i] != '0 && nhi_c[i] != '0 &&
				nlo_c[i][CW] != nhi_c[i][CW]);
		end
	end

	logic               valid_s1;
	side_t              sb_s1;
	logic [2:0][CW:0]   unlo_s1, unhi_s1;
	logic [2:0][CW-1:0] ud_s1;
	logic [2:0]         neglo_s1, neghi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1    <= sb_c;
			unlo_s1  <= unlo_c;
			unhi_s1  <= unhi_c;
			ud_s1    <= ud_c;
			neglo_s1 <= neglo_c;
			neghi_s1 <= neghi_c;
		end
	end

	// Six dividers, two per axis.
	logic signed [FW+1:0] tlo [3];
	logic signed [FW+1:0] thi [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		sbsi_div #(.CW(CW), .FW(FW)) u_div_lo (
			.clk (clk),
			.en  (en),
			.un  (unlo_s1[i]),
			.ud  (ud_s1[i]),
			.neg (neglo_s1[i]),
			.t   (tlo[i])
		);
		sbsi_div #(.CW(CW), .FW(FW)) u_div_hi (
			.clk (clk),
			.en  (en),
			.un  (unhi_s1[i]),
			.ud  (ud_s1[i]),
			.neg (neghi_s1[i]),
			.t   (thi[i])
		);
	end

	// Side information delayed to match the divider latency.
	side_t sb_s2    [LD];
	logic  valid_s2 [LD];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2[0] <= sb_s1;
			for (int k = 1; k < LD; k++) begin
				sb_s2[k] <= sb_s2[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k < LD; k++) begin
				valid_s2[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s1    <= query_valid;
			valid_s2[0] <= valid_s1;
			for (int k = 1; k < LD; k++) begin
				valid_s2[k] <= valid_s2[k-1];
			end
		end
	end

	// Stage 3: per-axis entry and exit.
	logic signed [FW+1:0] near_c [3];
	logic signed [FW+1:0] far_c  [3];

	for (genvar i = 0; i < 3; i++) begin : g_s3
		always_comb begin
			if (sb_s2[LD-1].unb[i]) begin
				near_c[i] = T_MIN;
				far_c[i]  = T_MAX;
			end else if (tlo[i] < thi[i]) begin
				near_c[i] = tlo[i];
				far_c[i]  = thi[i];
			end else begin
				near_c[i] = thi[i];
				far_c[i]  = tlo[i];
			end
		end
	end

	logic                 valid_s3;
	side_t                sb_s3;
	logic signed [FW+1:0] near_s3 [3];
	logic signed [FW+1:0] far_s3  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb_s2[LD-1];
			for (int i = 0; i < 3; i++) begin
				near_s3[i] <= near_c[i];
				far_s3[i]  <= far_c[i];
			end
		end
	end

	// Stage 4: latest entry, earliest exit, hit decision and clamped t.
	logic signed [FW+1:0] nmax_c, fmin_c;
	logic                 ok_c;
	logic [FW:0]          th_c;

	always_comb begin
		nmax_c = near_s3[0];
		fmin_c = far_s3[0];
		for (int i = 1; i < 3; i++) begin
			if (near_s3[i] > nmax_c) begin
				nmax_c = near_s3[i];
			end
			if (far_s3[i] < fmin_c) begin
				fmin_c = far_s3[i];
			end
		end
		ok_c = (sb_s3.aok == 3'b111) && !fmin_c[FW+1] && !(nmax_c > T_ONE);
		th_c = nmax_c[FW+1] ? '0 : nmax_c[FW:0];
	end

	logic        valid_s4;
	side_t       sb_s4;
	logic        ok_s4;
	logic [FW:0] th_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4 <= sb_s3;
			ok_s4 <= ok_c;
			th_s4 <= th_c;
		end
	end

	// Stages 5 and 6: hit point per axis.
	logic signed [CW-1:0] p_s6 [3];

	for (genvar i = 0; i < 3; i++) begin : g_pt
		sbsi_point #(.CW(CW), .FW(FW)) u_point (
			.clk (clk),
			.en  (en),
			.o   (signed'(sb_s4.o[i])),
			.d   (signed'(sb_s4.d[i])),
			.th  (th_s4),
			.p   (p_s6[i])
		);
	end

	logic               valid_s5, valid_s6;
	logic               ok_s5, ok_s6;
	logic [2:0][CW-1:0] lo_s5, hi_s5, lo_s6, hi_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= ok_s4;
			lo_s5 <= sb_s4.lo;
			hi_s5 <= sb_s4.hi;
			ok_s6 <= ok_s5;
			lo_s6 <= lo_s5;
			hi_s6 <= hi_s5;
		end
	end

	// Stage 7: face selection by first exact match, and result formatting.
	logic [2:0]            face_c;
	sbsi_pkg::result_t     res_c;

	always_comb begin
		priority if (p_s6[0] == signed'(lo_s6[0])) begin
			face_c = sbsi_pkg::FACE_MIN_X;
		end else if (p_s6[0] == signed'(hi_s6[0])) begin
			face_c = sbsi_pkg::FACE_MAX_X;
		end else if (p_s6[1] == signed'(lo_s6[1])) begin
			face_c = sbsi_pkg::FACE_MIN_Y;
		end else if (p_s6[1] == signed'(hi_s6[1])) begin
			face_c = sbsi_pkg::FACE_MAX_Y;
		end else if (p_s6[2] == signed'(lo_s6[2])) begin
			face_c = sbsi_pkg::FACE_MIN_Z;
		end else if (p_s6[2] == signed'(hi_s6[2])) begin
			face_c = sbsi_pkg::FACE_MAX_Z;
		end else begin
			face_c = sbsi_pkg::FACE_NONE;
		end
		if (ok_s6) begin
			res_c.hit      = 1'b1;
			res_c.hit_x    = OW'(p_s6[0]);
			res_c.hit_y    = OW'(p_s6[1]);
			res_c.hit_z    = OW'(p_s6[2]);
			res_c.hit_face = face_c;
		end else begin
			res_c.hit      = 1'b0;
			res_c.hit_x    = '0;
			res_c.hit_y    = '0;
			res_c.hit_z    = '0;
			res_c.hit_face = sbsi_pkg::FACE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			valid_s6     <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			valid_s3     <= valid_s2[LD-1];
			valid_s4     <= valid_s3;
			valid_s5     <= valid_s4;
			valid_s6     <= valid_s5;
			result_valid <= valid_s6;
		end
	end

endmodule

// File: test/segment_box_slab_intersect_checker.sv
// Checker that predicts and compares the slab intersection results.
`timescale 1ns / 1ps
module segment_box_slab_intersect_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	input  logic              query_stall,
	input  sbsi_pkg::query_t  query,
	input  logic              result_valid,
	input  logic              result_stall,
	input  sbsi_pkg::result_t result,
	output int                fail_count,
	output int                pending_count
);

	localparam int FRAC = 16;
	localparam longint T_ONE = 64'sd1 <<< FRAC;
	localparam longint T_TOP = (64'sd1 <<< (FRAC + 1)) - 1;
	localparam longint T_BOT = -T_TOP - 1;
	localparam longint C_TOP = 64'sd2147483647;
	localparam longint C_BOT = -64'sd2147483648;

	sbsi_pkg::result_t expected_hits[$];

	// Floored quotient num * 2^FRAC / den, clamped to the t range.
	function automatic longint slab_quotient(longint num, longint den);
		longint un, ud, q, r;
		bit neg;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		if (un >= 2 * ud)
			return neg ? T_BOT : T_TOP;
		q = (un >= ud) ? 1 : 0;
		r = un - q * ud;
		for (int i = 0; i < FRAC; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 1;
			end
		end
		if (neg)
			return -q - ((r != 0) ? 1 : 0);
		return q;
	endfunction

	// Start plus floored delta * t, clamped to the coordinate range.
	function automatic longint step_along(longint o, longint d, longint t);
		longint um, a, b, bt, p, s;
		um = (d < 0) ? -d : d;
		a = um >>> FRAC;
		b = um & ((64'sd1 <<< FRAC) - 1);
		bt = b * t;
		p = a * t + (bt >>> FRAC);
		if (d < 0)
			p = -p - (((bt & ((64'sd1 <<< FRAC) - 1)) != 0) ? 1 : 0);
		s = o + p;
		if (s > C_TOP) s = C_TOP;
		if (s < C_BOT) s = C_BOT;
		return s;
	endfunction

	function automatic sbsi_pkg::result_t predict_hit(sbsi_pkg::query_t q);
		longint o[3], d[3], lo[3], hi[3], pt[3];
		longint t_near, t_far, a, b, th;
		bit ok;
		sbsi_pkg::result_t r;
		o = '{longint'(q.origin_x), longint'(q.origin_y), longint'(q.origin_z)};
		d = '{longint'(q.delta_x), longint'(q.delta_y), longint'(q.delta_z)};
		lo = '{longint'(q.box_min_x), longint'(q.box_min_y), longint'(q.box_min_z)};
		hi = '{longint'(q.box_max_x), longint'(q.box_max_y), longint'(q.box_max_z)};
		t_near = T_BOT;
		t_far = T_TOP;
		ok = 1;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			if (d[i] == 0) begin
				// A flat axis only passes when the start lies strictly inside the slab.
				if (lo[i] == o[i] || hi[i] == o[i] || ((lo[i] < o[i]) == (hi[i] < o[i])))
					ok = 0;
			end else begin
				a = slab_quotient(lo[i] - o[i], d[i]);
				b = slab_quotient(hi[i] - o[i], d[i]);
				if (((a < b) ? a : b) > t_near) t_near = (a < b) ? a : b;
				if (((a < b) ? b : a) < t_far) t_far = (a < b) ? b : a;
			end
		end
		if (!ok || t_far < 0 || t_near > T_ONE)
			return r;
		th = (t_near > 0) ? t_near : 0;
		for (int i = 0; i < 3; i++)
			pt[i] = step_along(o[i], d[i], th);
		r.hit = 1'b1;
		r.hit_x = pt[0][31:0];
		r.hit_y = pt[1][31:0];
		r.hit_z = pt[2][31:0];
		r.hit_face = sbsi_pkg::FACE_NONE;
		if (pt[0] == lo[0]) r.hit_face = sbsi_pkg::FACE_MIN_X;
		else if (pt[0] == hi[0]) r.hit_face = sbsi_pkg::FACE_MAX_X;
		else if (pt[1] == lo[1]) r.hit_face = sbsi_pkg::FACE_MIN_Y;
		else if (pt[1] == hi[1]) r.hit_face = sbsi_pkg::FACE_MAX_Y;
		else if (pt[2] == lo[2]) r.hit_face = sbsi_pkg::FACE_MIN_Z;
		else if (pt[2] == hi[2]) r.hit_face = sbsi_pkg::FACE_MAX_Z;
		return r;
	endfunction

	assign pending_count = expected_hits.size();

	// Predict on each query transfer and compare on each result transfer.
	always @(posedge clk or negedge arst_n) begin
		sbsi_pkg::result_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (query_valid && !query_stall)
				expected_hits.push_back(predict_hit(query));
			if (result_valid && !result_stall) begin
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (want.hit !== result.hit || want.hit_x !== result.hit_x ||
					    want.hit_y !== result.hit_y || want.hit_z !== result.hit_z ||
					    want.hit_face !== result.hit_face) begin
						$display("%0t: mismatch expected hit=%0b p=(%h,%h,%h) face=%0d",
							$time, want.hit, want.hit_x, want.hit_y, want.hit_z,
							want.hit_face);
						$display("%0t:          actual   hit=%0b p=(%h,%h,%h) face=%0d",
							$time, result.hit, result.hit_x, result.hit_y, result.hit_z,
							result.hit_face);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: test/segment_box_slab_intersect_tb.sv
// Testbench top that drives segment box queries and reports the verdict.
`timescale 1ns / 1ps
module segment_box_slab_intersect_tb;

	localparam int LATENCY = 24;
	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic query_valid = 0;
	logic query_stall;
	sbsi_pkg::query_t query = '0;
	logic result_valid;
	logic result_stall = 0;
	sbsi_pkg::result_t result;
	int fail_count, pending_count;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit recv_hold = 0;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	segment_box_slab_intersect i_dut (.*);

	segment_box_slab_intersect_checker i_checker (.*);

	// Random coordinate, mostly small, sometimes full range or an extreme.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
			default: return 32'(signed'($urandom_range(0, 20'hfffff)) - 20'sh80000);
		endcase
	endfunction

	// Random query, usually a box around a region with a segment often crossing it.
	function automatic sbsi_pkg::query_t make_query();
		sbsi_pkg::query_t q;
		logic [31:0] c, h;
		for (int i = 0; i < 12; i++)
			q[i*32 +: 32] = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			c = rand_coord();
			h = $urandom_range(1, 20'h3ffff);
			q.box_min_x = c - h; q.box_max_x = c + h;
			q.box_min_y = c - h; q.box_max_y = c + h;
			q.box_min_z = c - h; q.box_max_z = c + h;
			q.origin_x = c - 3 * h + $urandom_range(0, 1);
			q.origin_y = c + $urandom_range(0, 7) - 3;
			q.origin_z = c;
			q.delta_x = 6 * h;
			q.delta_y = $urandom_range(0, 2) == 0 ? 0 : 32'($urandom_range(0, 20'hffff)) - 16'h8000;
			q.delta_z = $urandom_range(0, 3) == 0 ? 0 : 32'($urandom_range(0, 20'hffff)) - 16'h8000;
			if ($urandom_range(0, 1)) begin
				q.origin_x = c + 3 * h;
				q.delta_x = -6 * h;
			end
		end
		return q;
	endfunction

	function automatic sbsi_pkg::query_t box_query(int ox, int oy, int oz, int dx, int dy, int dz,
	                                               int lx, int ly, int lz, int hx, int hy, int hz);
		sbsi_pkg::query_t q;
		q.origin_x = ox <<< 16; q.origin_y = oy <<< 16; q.origin_z = oz <<< 16;
		q.delta_x = dx <<< 16; q.delta_y = dy <<< 16; q.delta_z = dz <<< 16;
		q.box_min_x = lx <<< 16; q.box_min_y = ly <<< 16; q.box_min_z = lz <<< 16;
		q.box_max_x = hx <<< 16; q.box_max_y = hy <<< 16; q.box_max_z = hz <<< 16;
		return q;
	endfunction

	// Offer one query and hold it until transfer.
	task automatic send_query(sbsi_pkg::query_t q);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		@(posedge clk);
		while (query_stall) @(posedge clk);
	endtask

	task automatic drain();
		query_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
	endtask

	// Receiver stall, plus a long hold-off on request.
	always @(posedge clk) begin
		if (recv_hold)
			result_stall <= 1'b1;
		else
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Watchdog on cycles with no transfer.
	always @(posedge clk) begin
		if ((query_valid && !query_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		sbsi_pkg::query_t q;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: hits on each face, misses, flat axes and extremes.
		send_query(box_query(-5, 0, 0, 10, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(5, 0, 0, -10, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, -5, 0, 0, 10, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, 5, 0, 0, -10, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, 0, -5, 0, 0, 10, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, 0, 5, 0, 0, -10, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, 0, 0, 1, 1, 1, -1, -1, -1, 1, 1, 1));
		send_query(box_query(1, 0, 0, 0, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(5, 0, 0, 0, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(-5, 0, 0, 2, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(5, 0, 0, 2, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(-5, 0, 0, 10, 0, 0, 1, -1, -1, -1, 1, 1));
		send_query(box_query(-4, 0, 0, 3, 0, 0, -1, -1, -1, 1, 1, 1));
		send_query(box_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		q = '0;
		q.origin_x = 32'h80000000; q.delta_x = 32'h7fffffff;
		q.box_min_x = 32'h80000000; q.box_max_x = 32'h7fffffff;
		q.box_min_y = 32'h80000000; q.box_max_y = 32'h7fffffff;
		q.box_min_z = 32'h80000000; q.box_max_z = 32'h7fffffff;
		send_query(q);
		q.origin_x = 32'h7fffffff; q.delta_x = 32'h80000000;
		send_query(q);
		q = '1;
		send_query(q);
		q = {12{32'h55555555}};
		send_query(q);
		q = {12{32'haaaaaaaa}};
		send_query(q);
		q = box_query(-3, -3, -3, 7, 5, 6, -1, -2, -1, 2, 1, 2);
		q.delta_x = q.delta_x + 1;
		send_query(q);
		drain();

		// Random phases with different idling.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				3: begin send_idle_pct = 21; recv_stall_pct = 21; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 325; n++) begin
				// Long receiver hold-off while the sender keeps offering.
				if (phase == 4 && n == 20)
					fork
						begin
							recv_hold = 1;
							repeat (200) @(posedge clk);
							recv_hold = 0;
						end
					join_none
				// Sender pause until all results are back.
				if (phase == 0 && n == 160)
					drain();
				send_query(make_query());
			end
		end
		drain();
		repeat (LATENCY + 8) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/sbsi_pkg.sv
hw/rtl/sbsi_div.sv
hw/rtl/sbsi_point.sv
hw/rtl/segment_box_slab_intersect.sv
test/segment_box_slab_intersect_checker.sv
test/segment_box_slab_intersect_tb.sv
